### src/b64s_pkg.sv
// Shared types, constants and character functions for the base64 stream codec.
// Used by b64s_step, b64s_resbuf and base64_stream_codec; depends on nothing else.

package b64s_pkg;

	localparam int MAX_RES = 4;

	// Register indexes of the configuration port.
	localparam logic REG_DIRECTION = 1'b0;
	localparam logic REG_URL       = 1'b1;

	// Direction codes.
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// Character decoder codes beyond the 6-bit values.
	localparam logic [6:0] DEC_SKIP = 7'd64;
	localparam logic [6:0] DEC_BAD  = 7'd65;

	localparam logic [7:0] CHAR_PAD   = 8'h3D; // '='
	localparam logic [7:0] CHAR_MINUS = 8'h2D; // '-'
	localparam logic [7:0] CHAR_UNDER = 8'h5F; // '_'
	localparam logic [7:0] CHAR_PLUS  = 8'h2B; // '+'
	localparam logic [7:0] CHAR_SLASH = 8'h2F; // '/'
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;

	typedef struct packed {
		logic direction;
		logic url_alphabet;
	} cfg_t;

	typedef struct packed {
		logic [5:0] bits;
		logic [2:0] count;
		logic [1:0] phase;
		logic       bad;
	} msg_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       last;
		logic       status;
	} result_t;

	typedef result_t [MAX_RES-1:0] res_vec_t;

	function automatic logic [7:0] enc_char(input logic [5:0] v, input logic url);
		logic [7:0] c;
		c = 8'h00;
		if (v < 6'd26)
			c = CHAR_UPPER_A + {2'b00, v};
		else if (v < 6'd52)
			c = CHAR_LOWER_A + {2'b00, v - 6'd26};
		else if (v < 6'd62)
			c = CHAR_ZERO + {2'b00, v - 6'd52};
		else if (v == 6'd62)
			c = url ? CHAR_MINUS : CHAR_PLUS;
		else
			c = url ? CHAR_UNDER : CHAR_SLASH;
		return c;
	endfunction

	function automatic logic [6:0] dec_value(input logic [7:0] c, input logic url);
		logic [6:0] d;
		d = DEC_BAD;
		if (c >= 8'h41 && c <= 8'h5A)
			d = 7'(c - CHAR_UPPER_A);
		else if (c >= 8'h61 && c <= 8'h7A)
			d = 7'(c - CHAR_LOWER_A + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39)
			d = 7'(c - CHAR_ZERO + 8'd52);
		else if (c == CHAR_PLUS)
			d = 7'd62;
		else if (c == CHAR_SLASH)
			d = 7'd63;
		else if (url && c == CHAR_MINUS)
			d = 7'd62;
		else if (url && c == CHAR_UNDER)
			d = 7'd63;
		else if (c == CHAR_PAD || c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D))
			d = DEC_SKIP;
		return d;
	endfunction

endpackage

### src/b64s_step.sv
// Combinational work for one word: merges it with the leftover bits and builds
// up to four results plus the next message state. Depends on b64s_pkg.

module b64s_step (
	input  b64s_pkg::cfg_t       cfg,
	input  b64s_pkg::msg_state_t st,
	input  logic [7:0]           in_byte,
	input  logic                 has_byte,
	input  logic                 end_of_message,
	output b64s_pkg::res_vec_t   res,
	output logic [2:0]           res_n,
	output b64s_pkg::msg_state_t nxt
);

	logic [13:0] acc14;
	logic [11:0] acc12;
	logic [3:0]  t;
	logic [5:0]  ch;
	logic [6:0]  d;
	logic [2:0]  n;
	logic [2:0]  lidx;
	logic [1:0]  phase;
	logic [5:0]  bits;
	logic [2:0]  cnt;
	logic        bad_now;

	always_comb begin
		res     = '0;
		n       = 3'd0;
		phase   = st.phase;
		bits    = st.bits;
		cnt     = st.count;
		bad_now = st.bad;
		acc14   = {st.bits, in_byte};
		acc12   = '0;
		t       = 4'd0;
		ch      = 6'd0;
		d       = b64s_pkg::dec_value(in_byte, cfg.url_alphabet);
		lidx    = 3'd0;

		if (cfg.direction == b64s_pkg::DIR_ENCODE) begin
			if (has_byte) begin
				t  = {1'b0, st.count} + 4'd8 - 4'd6;
				ch = 6'(acc14 >> t);
				res[n[1:0]] = '{b64s_pkg::enc_char(ch, cfg.url_alphabet), 1'b1, 1'b0, bad_now};
				n     = n + 3'd1;
				phase = phase + 2'd1;
				if (t >= 4'd6) begin
					t  = t - 4'd6;
					ch = 6'(acc14 >> t);
					res[n[1:0]] = '{b64s_pkg::enc_char(ch, cfg.url_alphabet), 1'b1, 1'b0,
						bad_now};
					n     = n + 3'd1;
					phase = phase + 2'd1;
				end
				bits = acc14[5:0] & 6'((7'd1 << t) - 7'd1);
				cnt  = t[2:0];
			end
			if (end_of_message) begin
				// Flush the tail bits, zero-filled on the right.
				if (cnt != 3'd0 && cnt < 3'd6) begin
					ch = 6'(bits << (3'd6 - cnt));
					res[n[1:0]] = '{b64s_pkg::enc_char(ch, cfg.url_alphabet), 1'b1, 1'b0,
						bad_now};
					n     = n + 3'd1;
					phase = phase + 2'd1;
				end
				if (!cfg.url_alphabet) begin
					for (int i = 0; i < 3; i++) begin
						if (phase != 2'd0 && n < 3'(b64s_pkg::MAX_RES)) begin
							res[n[1:0]] = '{b64s_pkg::CHAR_PAD, 1'b1, 1'b0, bad_now};
							n     = n + 3'd1;
							phase = phase + 2'd1;
						end
					end
				end
			end
		end else begin
			if (has_byte && !st.bad) begin
				if (d == b64s_pkg::DEC_BAD) begin
					bad_now = 1'b1;
				end else if (d != b64s_pkg::DEC_SKIP) begin
					acc12 = {st.bits, d[5:0]};
					t     = {1'b0, st.count} + 4'd6;
					if (t >= 4'd8) begin
						t = t - 4'd8;
						res[n[1:0]] = '{8'(acc12 >> t), 1'b1, 1'b0, bad_now};
						n = n + 3'd1;
					end
					bits = acc12[5:0] & 6'((7'd1 << t) - 7'd1);
					cnt  = t[2:0];
				end
			end
		end

		nxt = '{bits, cnt, phase, bad_now};

		if (end_of_message) begin
			// An end word that yields no data still closes the message with a marker.
			if (n == 3'd0) begin
				res[0] = '{8'h00, 1'b0, 1'b0, bad_now};
				n = 3'd1;
			end
			lidx = n - 3'd1;
			res[lidx[1:0]].last = 1'b1;
			nxt = '0;
		end

		res_n = n;
	end

endmodule

### src/b64s_resbuf.sv
// Result register bank: holds the results of one word and hands them out one
// per cycle on the valid/stall channel while res_stall is low. Depends on b64s_pkg.

module b64s_resbuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  b64s_pkg::res_vec_t load_res,
	input  logic [2:0]         load_n,
	input  logic               res_stall,
	output logic               ready,
	output logic               res_valid,
	output b64s_pkg::result_t  res
);

	b64s_pkg::res_vec_t res_q;
	logic [2:0]         rem_q;
	logic [1:0]         rd_q;
	logic               take;

	assign res_valid = (rem_q != 3'd0);
	assign take      = res_valid && !res_stall;
	// A new set may come in as the last pending result leaves.
	assign ready     = (rem_q == 3'd0) || (rem_q == 3'd1 && take);
	assign res       = res_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			rd_q  <= 2'd0;
		end else if (load) begin
			rem_q <= load_n;
			rd_q  <= 2'd0;
		end else if (take) begin
			rem_q <= rem_q - 3'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= load_res;
	end

endmodule

### src/base64_stream_codec.sv
// Top level of the base64 stream codec: configuration registers, input register,
// message state and result bank. Depends on b64s_pkg, b64s_step and b64s_resbuf.

// A word is taken into an input register, worked on in one pass of logic and its
// up to four results are placed in a result bank, which hands out one result per
// cycle unless res_stall holds it. A word's results are loaded into the bank when
// it is empty or as its last pending result leaves. Encoding yields one or two
// characters per byte (four characters per three bytes) and up to three more at
// the end of a message for the flushed character and padding; decoding yields at
// most one byte per character.
// Configuration writes abandon any message in progress and must be made while the
// block is idle.

module base64_stream_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       has_byte,
	input  logic       end_of_message,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       last,
	output logic       status
);

	b64s_pkg::cfg_t       cfg_q;
	b64s_pkg::msg_state_t st_q;
	b64s_pkg::msg_state_t st_nxt;
	b64s_pkg::res_vec_t   step_res;
	b64s_pkg::result_t    cur_res;
	logic [2:0]           step_n;
	logic                 vld_s1;
	logic [7:0]           byte_s1;
	logic                 has_s1;
	logic                 eom_s1;
	logic                 buf_ready;
	logic                 advance;
	logic                 accept;

	assign advance  = vld_s1 && buf_ready;
	assign in_stall = vld_s1 && !buf_ready;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= '0;
			st_q   <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == b64s_pkg::REG_DIRECTION)
					cfg_q.direction <= cfg_data;
				else
					cfg_q.url_alphabet <= cfg_data;
				st_q <= '0;
			end else if (advance) begin
				st_q <= st_nxt;
			end
			if (accept)
				vld_s1 <= 1'b1;
			else if (advance)
				vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			has_s1  <= has_byte;
			eom_s1  <= end_of_message;
		end
	end

	b64s_step u_step (
		.cfg            (cfg_q),
		.st             (st_q),
		.in_byte        (byte_s1),
		.has_byte       (has_s1),
		.end_of_message (eom_s1),
		.res            (step_res),
		.res_n          (step_n),
		.nxt            (st_nxt)
	);

	b64s_resbuf u_resbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.load_res  (step_res),
		.load_n    (step_n),
		.res_stall (res_stall),
		.ready     (buf_ready),
		.res_valid (res_valid),
		.res       (cur_res)
	);

	assign out_byte  = cur_res.out_byte;
	assign out_valid = cur_res.out_valid;
	assign last      = cur_res.last;
	assign status    = cur_res.status;

endmodule
